// ===== hw/rtl/bsu_pkg.sv =====
// shared types, codes and utf-8 helpers for the bom sniffing transcoder
package bsu_pkg;

  localparam logic [7:0] BOM8_0    = 8'hEF;
  localparam logic [7:0] BOM8_1    = 8'hBB;
  localparam logic [7:0] BOM8_2    = 8'hBF;
  localparam logic [7:0] BOM16_FF  = 8'hFF;
  localparam logic [7:0] BOM16_FE  = 8'hFE;
  localparam logic [15:0] HIGH_MIN = 16'hD800;
  localparam logic [15:0] HIGH_MAX = 16'hDBFF;
  localparam logic [15:0] LOW_MIN  = 16'hDC00;
  localparam logic [15:0] LOW_MAX  = 16'hDFFF;
  localparam logic [20:0] SUPP_BASE = 21'h10000;
  localparam logic [20:0] CP_1B_MAX = 21'h00007F;
  localparam logic [20:0] CP_2B_MAX = 21'h0007FF;
  localparam logic [20:0] CP_3B_MAX = 21'h00FFFF;

  typedef enum logic [3:0] {
    MODE_UNDEC = 4'b0001,
    MODE_PASS  = 4'b0010,
    MODE_LE    = 4'b0100,
    MODE_BE    = 4'b1000
  } mode_t;

  typedef logic [3:0][7:0] quad_t;
  typedef logic [5:0][7:0] six_t;

  typedef struct packed {
    quad_t      bytes;
    logic [2:0] cnt;
  } utf8_t;

  // one request worth of output: cnt zero with last set is a bare end marker
  typedef struct packed {
    six_t       bytes;
    logic [2:0] cnt;
    logic       last;
  } job_t;

  function automatic utf8_t encode(input logic [20:0] cp);
    utf8_t r;
    r = '0;
    if (cp <= CP_1B_MAX) begin
      r.bytes[0] = cp[7:0];
      r.cnt = 3'd1;
    end else if (cp <= CP_2B_MAX) begin
      r.bytes[0] = {3'b110, cp[10:6]};
      r.bytes[1] = {2'b10, cp[5:0]};
      r.cnt = 3'd2;
    end else if (cp <= CP_3B_MAX) begin
      r.bytes[0] = {4'b1110, cp[15:12]};
      r.bytes[1] = {2'b10, cp[11:6]};
      r.bytes[2] = {2'b10, cp[5:0]};
      r.cnt = 3'd3;
    end else begin
      r.bytes[0] = {5'b11110, cp[20:18]};
      r.bytes[1] = {2'b10, cp[17:12]};
      r.bytes[2] = {2'b10, cp[11:6]};
      r.bytes[3] = {2'b10, cp[5:0]};
      r.cnt = 3'd4;
    end
    return r;
  endfunction

  // place b right after the valid bytes of a
  function automatic six_t combine(input utf8_t a, input utf8_t b);
    six_t       r;
    logic [2:0] k;
    r = '0;
    for (int i = 0; i < 6; i++) begin
      k = 3'(i) - a.cnt;
      if (3'(i) < a.cnt) begin
        r[i] = a.bytes[2'(i)];
      end else if (k < b.cnt) begin
        r[i] = b.bytes[k[1:0]];
      end
    end
    return r;
  endfunction

endpackage

// ===== hw/rtl/bsu_front.sv =====
// front end: bom sniffing, code unit assembly, surrogate pairing, utf-8 encode
module bsu_front import bsu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] data_byte,
  input  logic       end_of_file,
  output logic       push,
  output job_t       job
);

  logic [1:0]  pos, pos_next;
  mode_t       mode, mode_next;
  logic [7:0]  held0, held0_next, held1, held1_next;
  logic        half, half_next;
  logic [7:0]  first, first_next;
  logic        hp, hp_next;
  logic [15:0] hs, hs_next;
  logic [15:0] unit;
  logic        is_high, is_low;
  utf8_t       ea, eb;

  assign unit    = (mode == MODE_BE) ? {first, data_byte} : {data_byte, first};
  assign is_high = (unit >= HIGH_MIN) && (unit <= HIGH_MAX);
  assign is_low  = (unit >= LOW_MIN) && (unit <= LOW_MAX);

  always_comb begin
    pos_next   = pos;
    mode_next  = mode;
    held0_next = held0;
    held1_next = held1;
    half_next  = half;
    first_next = first;
    hp_next    = hp;
    hs_next    = hs;
    ea = '0;
    eb = '0;
    unique case (mode)
      MODE_UNDEC: begin
        case (pos)
          2'd0: begin
            if (data_byte == BOM8_0 || data_byte == BOM16_FF || data_byte == BOM16_FE) begin
              held0_next = data_byte;
              pos_next = 2'd1;
              if (end_of_file) begin
                ea.bytes[0] = data_byte;
                ea.cnt = 3'd1;
              end
            end else begin
              mode_next = MODE_PASS;
              ea.bytes[0] = data_byte;
              ea.cnt = 3'd1;
            end
          end
          2'd1: begin
            if (held0 == BOM8_0 && data_byte == BOM8_1) begin
              held1_next = data_byte;
              pos_next = 2'd2;
              if (end_of_file) begin
                ea.bytes[0] = held0;
                ea.bytes[1] = data_byte;
                ea.cnt = 3'd2;
              end
            end else if (held0 == BOM16_FF && data_byte == BOM16_FE) begin
              mode_next = MODE_LE;
              pos_next = 2'd0;
            end else if (held0 == BOM16_FE && data_byte == BOM16_FF) begin
              mode_next = MODE_BE;
              pos_next = 2'd0;
            end else begin
              mode_next = MODE_PASS;
              pos_next = 2'd0;
              ea.bytes[0] = held0;
              ea.bytes[1] = data_byte;
              ea.cnt = 3'd2;
            end
          end
          default: begin
            mode_next = MODE_PASS;
            pos_next = 2'd0;
            // full utf-8 mark is dropped, anything else releases the held bytes
            if (data_byte != BOM8_2) begin
              ea.bytes[0] = held0;
              ea.bytes[1] = held1;
              ea.bytes[2] = data_byte;
              ea.cnt = 3'd3;
            end
          end
        endcase
      end
      MODE_PASS: begin
        ea.bytes[0] = data_byte;
        ea.cnt = 3'd1;
      end
      default: begin
        if (!half) begin
          first_next = data_byte;
          half_next = 1'b1;
          if (end_of_file && hp) begin
            ea = encode({5'd0, hs});
            hp_next = 1'b0;
          end
        end else begin
          half_next = 1'b0;
          if (hp && is_low) begin
            ea = encode(SUPP_BASE + {1'b0, hs[9:0], unit[9:0]});
            hp_next = 1'b0;
          end else begin
            // unpaired high goes out alone, this unit is handled fresh
            if (hp) begin
              ea = encode({5'd0, hs});
              hp_next = 1'b0;
            end
            if (is_high && !end_of_file) begin
              hp_next = 1'b1;
              hs_next = unit;
            end else begin
              eb = encode({5'd0, unit});
            end
          end
        end
      end
    endcase
    if (end_of_file) begin
      pos_next  = 2'd0;
      mode_next = MODE_UNDEC;
      half_next = 1'b0;
      hp_next   = 1'b0;
    end
  end

  assign job.bytes = combine(ea, eb);
  assign job.cnt   = ea.cnt + eb.cnt;
  assign job.last  = end_of_file;
  assign push      = accept && ((job.cnt != 3'd0) || end_of_file);

  always_ff @(posedge clk) begin
    if (rst) begin
      pos  <= 2'd0;
      mode <= MODE_UNDEC;
      half <= 1'b0;
      hp   <= 1'b0;
    end else if (accept) begin
      pos  <= pos_next;
      mode <= mode_next;
      half <= half_next;
      hp   <= hp_next;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      held0 <= held0_next;
      held1 <= held1_next;
      first <= first_next;
      hs    <= hs_next;
    end
  end

endmodule

// ===== hw/rtl/bsu_queue.sv =====
// two-entry queue of output requests between front and back
module bsu_queue import bsu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  job_t push_job,
  input  logic pop,
  output logic q_valid,
  output logic q_full,
  output job_t q_job
);

  job_t       entries [2];
  logic       wptr, rptr;
  logic [1:0] count;

  assign q_valid = (count != 2'd0);
  assign q_full  = (count == 2'd2);
  assign q_job   = entries[rptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wptr] <= push_job;
    end
  end

endmodule

// ===== hw/rtl/bsu_back.sv =====
// back end: plays out one request byte by byte on the output channel
module bsu_back import bsu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       q_valid,
  input  job_t       q_job,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       out_last
);

  job_t       cur;
  logic       busy;
  logic [2:0] idx;
  logic       idx_last;
  logic       done;

  // bare end marker is a single beat with no byte
  assign idx_last   = (cur.cnt == 3'd0) || (idx == cur.cnt - 3'd1);
  assign done       = busy && !out_stall && idx_last;
  assign pop        = q_valid && (!busy || done);

  assign out_valid  = busy;
  assign byte_valid = (cur.cnt != 3'd0);
  assign out_byte   = byte_valid ? cur.bytes[idx] : 8'd0;
  assign out_last   = cur.last && idx_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      idx  <= 3'd0;
    end else if (pop) begin
      busy <= 1'b1;
      idx  <= 3'd0;
    end else if (done) begin
      busy <= 1'b0;
    end else if (busy && !out_stall) begin
      idx <= idx + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_job;
    end
  end

endmodule

// ===== hw/rtl/bom_sniff_utf16_to_utf8.sv =====
// top level: bom sniffing front end, request queue and byte play-out back end
// an input byte is taken every cycle while the two-entry request queue has room
// its result bytes pass the request queue and the back end's current request register
// on the way out; the back end sends one byte per cycle while out_stall is low
// synchronous rst clears sniffing, mode, surrogate, queue and back end state; end of file
// returns the front end to its start state
module bom_sniff_utf16_to_utf8 import bsu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       end_of_file,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       byte_valid,
  output logic       out_last
);

  logic accept;
  logic push;
  job_t push_job;
  logic pop;
  logic q_valid;
  logic q_full;
  job_t q_job;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  bsu_front u_front (
    .clk        (clk),
    .rst        (rst),
    .accept     (accept),
    .data_byte  (data_byte),
    .end_of_file(end_of_file),
    .push       (push),
    .job        (push_job)
  );

  bsu_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_job(push_job),
    .pop     (pop),
    .q_valid (q_valid),
    .q_full  (q_full),
    .q_job   (q_job)
  );

  bsu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_job     (q_job),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_byte  (out_byte),
    .byte_valid(byte_valid),
    .out_last  (out_last)
  );

  a_no_push_full: assert property (@(posedge clk) disable iff (rst) push |-> !q_full)
    else $error("request pushed into full queue");

  a_pop_has_data: assert property (@(posedge clk) disable iff (rst) pop |-> q_valid)
    else $error("request popped from empty queue");

  a_bare_is_last: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !byte_valid) |-> out_last)
    else $error("bare marker without last");

  a_request_nonempty: assert property (@(posedge clk) disable iff (rst)
    push |-> (push_job.cnt != 3'd0 || push_job.last))
    else $error("empty request queued");

endmodule
